// ===== hdl/scst_pkg.sv =====
`timescale 1ns / 1ps

package scst_pkg;

  localparam int unsigned CMD_FIFO_DEPTH = 4;
  localparam int unsigned TBL_LEN = 58;

  localparam logic [7:0] PREFIX_E0   = 8'hE0;
  localparam logic [7:0] K_BACKSPACE = 8'h80;
  localparam logic [7:0] K_ENTER     = 8'h82;
  localparam logic [7:0] K_CTRL      = 8'h83;
  localparam logic [7:0] K_SHIFT     = 8'h84;
  localparam logic [7:0] K_ALT       = 8'h85;
  localparam logic [7:0] KEY_C       = 8'h63;
  localparam logic [7:0] SC_UP       = 8'h48;
  localparam logic [7:0] SC_LEFT     = 8'h4B;
  localparam logic [7:0] SC_RIGHT    = 8'h4D;
  localparam logic [7:0] SC_DOWN     = 8'h50;
  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_ONE      = 8'h31;
  localparam logic [7:0] CH_TWO      = 8'h32;
  localparam logic [7:0] CH_J        = 8'h4A;
  localparam logic [7:0] CH_H        = 8'h48;
  localparam logic [7:0] CH_A        = 8'h41;
  localparam logic [7:0] CH_B        = 8'h42;
  localparam logic [7:0] CH_C        = 8'h43;
  localparam logic [7:0] CH_D        = 8'h44;

  localparam logic [7:0] PLAIN_TBL [TBL_LEN] = '{
    8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h30, 8'h2D, 8'h3D, 8'h80, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
    8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h82, 8'h83,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h84, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
    8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h84, 8'h2A, 8'h85, 8'h20
  };

  localparam logic [7:0] SHIFT_TBL [TBL_LEN] = '{
    8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
    8'h28, 8'h29, 8'h5F, 8'h2B, 8'h80, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
    8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h82, 8'h83,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h84, 8'h5C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
    8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h84, 8'h2A, 8'h85, 8'h20
  };

  typedef enum logic [1:0] {
    CMD_CHAR  = 2'd0,
    CMD_BS    = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_ARROW = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] ch;
  } cmd_t;

  typedef struct packed {
    logic mid_seq;
  } back_stat_t;

  function automatic logic [7:0] tbl_lookup(input logic shifted, input logic [6:0] idx);
    logic [7:0] res;
    res = 8'h00;
    if (idx < 7'(TBL_LEN)) begin
      res = shifted ? SHIFT_TBL[idx[5:0]] : PLAIN_TBL[idx[5:0]];
    end
    return res;
  endfunction

  function automatic logic [2:0] seq_last(input cmd_kind_t kind);
    logic [2:0] res;
    unique case (kind)
      CMD_CHAR:  res = 3'd0;
      CMD_BS:    res = 3'd2;
      CMD_CLEAR: res = 3'd6;
      CMD_ARROW: res = 3'd3;
      default:   res = 3'd0;
    endcase
    return res;
  endfunction

  function automatic logic [7:0] seq_char(input cmd_t cmd, input logic [2:0] step);
    logic [7:0] res;
    res = cmd.ch;
    unique case (cmd.kind)
      CMD_CHAR: res = cmd.ch;
      CMD_BS:   res = (step == 3'd1) ? CH_SPACE : CH_BS;
      CMD_CLEAR: begin
        unique case (step)
          3'd0, 3'd4: res = CH_ESC;
          3'd1, 3'd5: res = CH_LBRACKET;
          3'd2:       res = CH_TWO;
          3'd3:       res = CH_J;
          3'd6:       res = CH_H;
          default:    res = CH_H;
        endcase
      end
      CMD_ARROW: begin
        unique case (step)
          3'd0:    res = CH_ESC;
          3'd1:    res = CH_LBRACKET;
          3'd2:    res = CH_ONE;
          default: res = cmd.ch;
        endcase
      end
      default: res = cmd.ch;
    endcase
    return res;
  endfunction

endpackage

// ===== hdl/scan_set1_to_terminal_chars.sv =====
`timescale 1ns / 1ps
// A request passes through the command queue and then the output character register.
// One request per cycle in while the queue has room, one character per cycle out while results
// are popped; a request emitting N characters (up to seven) holds the sequencer until its last.
// A four-entry command queue between decoder and sequencer absorbs result stalls.
// Reset (synchronous, active low) clears the modifier flags, the previous byte and all queues.
module scan_set1_to_terminal_chars #(
  parameter int unsigned CmdFifoDepth = scst_pkg::CMD_FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_scan_byte,
  input  logic       out_pop,
  output logic       out_empty,
  output logic [7:0] out_char_code,
  output logic       out_last_char
);

  logic                 cmd_push;
  logic                 cmd_pop;
  logic                 cmd_full;
  logic                 cmd_empty;
  scst_pkg::cmd_t       cmd_in;
  scst_pkg::cmd_t       cmd_head;
  scst_pkg::back_stat_t back_stat;

  assign in_full = cmd_full;

  scst_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_scan_byte (in_scan_byte),
    .cmd_full     (cmd_full),
    .cmd_push     (cmd_push),
    .cmd          (cmd_in)
  );

  scst_cmd_fifo #(
    .Depth (CmdFifoDepth)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (cmd_in),
    .pop      (cmd_pop),
    .full     (cmd_full),
    .empty    (cmd_empty),
    .head     (cmd_head)
  );

  scst_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_empty     (cmd_empty),
    .cmd           (cmd_head),
    .cmd_pop       (cmd_pop),
    .out_pop       (out_pop),
    .out_empty     (out_empty),
    .out_char_code (out_char_code),
    .out_last_char (out_last_char),
    .stat          (back_stat)
  );

  // A partly sent sequence always keeps its command at the queue head.
  a_mid_seq_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    back_stat.mid_seq |-> !cmd_empty)
    else $error("sequencer mid-sequence with empty command queue");

  // Taking a character that is not the last one is followed at once by the next one.
  a_seq_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pop && !out_empty && !out_last_char) |=> !out_empty)
    else $error("character sequence interrupted");

  // The queue only fills as a result of an accepted request.
  a_full_after_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_full) |-> $past(in_push && !in_full))
    else $error("command queue filled without an accepted request");

endmodule

// ===== hdl/scst_front.sv =====
`timescale 1ns / 1ps

module scst_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic [7:0]        in_scan_byte,
  input  logic              cmd_full,
  output logic              cmd_push,
  output scst_pkg::cmd_t    cmd
);

  logic       shift_r, shift_nxt;
  logic       ctrl_r, ctrl_nxt;
  logic       alt_r, alt_nxt;
  logic [7:0] prev_r, prev_nxt;
  logic       accept;
  logic       released;
  logic [7:0] code;
  logic [7:0] ch;
  logic       emit;

  assign accept   = in_push && !cmd_full;
  assign released = in_scan_byte[7];
  assign code     = scst_pkg::tbl_lookup(1'b0, in_scan_byte[6:0]);
  assign ch       = scst_pkg::tbl_lookup(shift_r, in_scan_byte[6:0]);

  always_comb begin
    shift_nxt = shift_r;
    ctrl_nxt  = ctrl_r;
    alt_nxt   = alt_r;
    prev_nxt  = prev_r;
    emit      = 1'b0;
    cmd.kind  = scst_pkg::CMD_CHAR;
    cmd.ch    = ch;
    if (accept) begin
      prev_nxt = in_scan_byte;
      if (released) begin
        if (code == scst_pkg::K_SHIFT) begin
          shift_nxt = 1'b0;
        end else if (code == scst_pkg::K_CTRL) begin
          ctrl_nxt = 1'b0;
        end else if (code == scst_pkg::K_ALT) begin
          alt_nxt = 1'b0;
        end
      end else if (code == scst_pkg::K_SHIFT) begin
        shift_nxt = 1'b1;
      end else if (code == scst_pkg::K_CTRL) begin
        ctrl_nxt = 1'b1;
      end else if (code == scst_pkg::K_ALT) begin
        alt_nxt = 1'b1;
      end else if (code == scst_pkg::K_BACKSPACE) begin
        emit     = 1'b1;
        cmd.kind = scst_pkg::CMD_BS;
      end else if (code == scst_pkg::K_ENTER) begin
        emit   = 1'b1;
        cmd.ch = scst_pkg::CH_LF;
      end else if (prev_r != scst_pkg::PREFIX_E0) begin
        if (ctrl_r && code == scst_pkg::KEY_C) begin
          emit     = 1'b1;
          cmd.kind = scst_pkg::CMD_CLEAR;
        end else begin
          emit = (ch != 8'h00);
        end
      end else begin
        cmd.kind = scst_pkg::CMD_ARROW;
        if (in_scan_byte == scst_pkg::SC_UP) begin
          emit   = 1'b1;
          cmd.ch = scst_pkg::CH_A;
        end else if (in_scan_byte == scst_pkg::SC_LEFT) begin
          emit   = 1'b1;
          cmd.ch = scst_pkg::CH_D;
        end else if (in_scan_byte == scst_pkg::SC_RIGHT) begin
          emit   = 1'b1;
          cmd.ch = scst_pkg::CH_C;
        end else if (in_scan_byte == scst_pkg::SC_DOWN) begin
          emit   = 1'b1;
          cmd.ch = scst_pkg::CH_B;
        end
      end
    end
  end

  assign cmd_push = emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= 1'b0;
      ctrl_r  <= 1'b0;
      alt_r   <= 1'b0;
      prev_r  <= 8'h00;
    end else begin
      shift_r <= shift_nxt;
      ctrl_r  <= ctrl_nxt;
      alt_r   <= alt_nxt;
      prev_r  <= prev_nxt;
    end
  end

endmodule

// ===== hdl/scst_cmd_fifo.sv =====
`timescale 1ns / 1ps

module scst_cmd_fifo #(
  parameter int unsigned Depth = scst_pkg::CMD_FIFO_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  scst_pkg::cmd_t    push_cmd,
  input  logic              pop,
  output logic              full,
  output logic              empty,
  output scst_pkg::cmd_t    head
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  scst_pkg::cmd_t mem_r [Depth];
  logic [PtrW-1:0] wr_r, wr_nxt;
  logic [PtrW-1:0] rd_r, rd_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push;
  logic            do_pop;

  assign full    = (cnt_r == CntW'(Depth));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == LastPtr) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == LastPtr) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_cmd;
    end
  end

endmodule

// ===== hdl/scst_back.sv =====
`timescale 1ns / 1ps

module scst_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmd_empty,
  input  scst_pkg::cmd_t        cmd,
  output logic                  cmd_pop,
  input  logic                  out_pop,
  output logic                  out_empty,
  output logic [7:0]            out_char_code,
  output logic                  out_last_char,
  output scst_pkg::back_stat_t  stat
);

  logic [2:0] step_r, step_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] char_r, char_nxt;
  logic       last_r, last_nxt;
  logic       advance;
  logic       fire;
  logic       at_end;

  assign advance = !valid_r || out_pop;
  assign fire    = advance && !cmd_empty;
  assign at_end  = (step_r == scst_pkg::seq_last(cmd.kind));
  assign cmd_pop = fire && at_end;

  always_comb begin
    step_nxt  = step_r;
    valid_nxt = valid_r;
    char_nxt  = char_r;
    last_nxt  = last_r;
    if (advance) begin
      valid_nxt = fire;
    end
    if (fire) begin
      char_nxt = scst_pkg::seq_char(cmd, step_r);
      last_nxt = at_end;
      step_nxt = at_end ? 3'd0 : step_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= 3'd0;
      valid_r <= 1'b0;
    end else begin
      step_r  <= step_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign out_empty     = !valid_r;
  assign out_char_code = char_r;
  assign out_last_char = last_r;
  assign stat.mid_seq  = (step_r != 3'd0);

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } term_char_t;

  // A row either carries its character here or leaves it to the decoder model.
  typedef struct packed {
    logic [7:0] scan;
    bit         typed;
    bit         has_char;
    logic [7:0] ch;
  } key_row_t;

  localparam int unsigned KEY_COUNT   = 58;
  localparam int unsigned RANDOM_KEYS = 218;
  localparam int unsigned HOLD_CYCLES = 120;

  localparam logic [7:0] RELEASE_BIT = 8'h80;
  localparam logic [7:0] SC_CTRL     = 8'h1D;
  localparam logic [7:0] SC_KEY_C    = 8'h2E;
  localparam logic [7:0] SC_LSHIFT   = 8'h2A;
  localparam logic [7:0] SC_RSHIFT   = 8'h36;
  localparam logic [7:0] SC_ALT      = 8'h38;

  localparam logic [7:0] PLAIN_KEYS [KEY_COUNT] = '{
    8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h30, 8'h2D, 8'h3D, 8'h80, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
    8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h82, 8'h83,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h84, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
    8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h84, 8'h2A, 8'h85, 8'h20
  };

  localparam logic [7:0] SHIFTED_KEYS [KEY_COUNT] = '{
    8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
    8'h28, 8'h29, 8'h5F, 8'h2B, 8'h80, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
    8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h82, 8'h83,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h84, 8'h5C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
    8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h84, 8'h2A, 8'h85, 8'h20
  };

  localparam logic [7:0] CLEAR_SEQ [7] = '{
    scst_pkg::CH_ESC, scst_pkg::CH_LBRACKET, scst_pkg::CH_TWO, scst_pkg::CH_J,
    scst_pkg::CH_ESC, scst_pkg::CH_LBRACKET, scst_pkg::CH_H
  };

  localparam logic [7:0] ARROW_KEYS [4] = '{
    scst_pkg::SC_UP, scst_pkg::SC_LEFT, scst_pkg::SC_RIGHT, scst_pkg::SC_DOWN
  };
  localparam logic [7:0] MOD_KEYS [4] = '{SC_LSHIFT, SC_RSHIFT, SC_CTRL, SC_ALT};

  key_row_t key_script [28] = '{
    '{8'h1E, 1'b1, 1'b1, 8'h61},
    '{8'h00, 1'b1, 1'b0, 8'h00},
    '{8'h7F, 1'b1, 1'b0, 8'h00},
    '{8'h39, 1'b1, 1'b1, scst_pkg::CH_SPACE},
    '{8'h0E, 1'b0, 1'b0, 8'h00},
    '{8'h1C, 1'b1, 1'b1, scst_pkg::CH_LF},
    '{SC_LSHIFT, 1'b1, 1'b0, 8'h00},
    '{8'h02, 1'b1, 1'b1, 8'h21},
    '{SC_LSHIFT | RELEASE_BIT, 1'b1, 1'b0, 8'h00},
    '{SC_RSHIFT, 1'b1, 1'b0, 8'h00},
    '{8'h10, 1'b0, 1'b0, 8'h00},
    '{SC_RSHIFT | RELEASE_BIT, 1'b1, 1'b0, 8'h00},
    '{SC_CTRL, 1'b1, 1'b0, 8'h00},
    '{SC_KEY_C, 1'b0, 1'b0, 8'h00},
    '{SC_CTRL | RELEASE_BIT, 1'b1, 1'b0, 8'h00},
    '{SC_ALT, 1'b1, 1'b0, 8'h00},
    '{SC_ALT | RELEASE_BIT, 1'b1, 1'b0, 8'h00},
    '{scst_pkg::PREFIX_E0, 1'b1, 1'b0, 8'h00},
    '{scst_pkg::SC_UP, 1'b0, 1'b0, 8'h00},
    '{scst_pkg::PREFIX_E0, 1'b1, 1'b0, 8'h00},
    '{scst_pkg::SC_LEFT, 1'b0, 1'b0, 8'h00},
    '{scst_pkg::PREFIX_E0, 1'b1, 1'b0, 8'h00},
    '{scst_pkg::SC_RIGHT, 1'b0, 1'b0, 8'h00},
    '{scst_pkg::PREFIX_E0, 1'b1, 1'b0, 8'h00},
    '{scst_pkg::SC_DOWN, 1'b0, 1'b0, 8'h00},
    '{scst_pkg::PREFIX_E0, 1'b1, 1'b0, 8'h00},
    '{8'h1E, 1'b1, 1'b0, 8'h00},
    '{8'hFF, 1'b1, 1'b0, 8'h00}
  };

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_push = 1'b0;
  logic       in_full;
  logic [7:0] in_scan_byte = 8'h00;
  logic       out_pop = 1'b0;
  logic       out_empty;
  logic [7:0] out_char_code;
  logic       out_last_char;

  term_char_t  pending_chars [$];
  logic        shift_on = 1'b0;
  logic        ctrl_on = 1'b0;
  logic        alt_on = 1'b0;
  logic [7:0]  prior_byte = 8'h00;
  bit          hold_outputs = 1'b0;
  bit          no_gaps = 1'b0;
  int unsigned burst_left = 0;
  int unsigned fail_count = 0;
  int unsigned sent_count = 0;
  int unsigned char_count = 0;
  int unsigned clear_count = 0;
  int unsigned arrow_count = 0;

  scan_set1_to_terminal_chars dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_scan_byte  (in_scan_byte),
    .out_pop       (out_pop),
    .out_empty     (out_empty),
    .out_char_code (out_char_code),
    .out_last_char (out_last_char)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  function automatic void add_char(input logic [7:0] code, input logic last, input bit record);
    if (record) begin
      pending_chars.push_back(term_char_t'{code, last});
    end
  endfunction

  function automatic void add_arrow(input logic [7:0] letter, input bit record);
    add_char(scst_pkg::CH_ESC, 1'b0, record);
    add_char(scst_pkg::CH_LBRACKET, 1'b0, record);
    add_char(scst_pkg::CH_ONE, 1'b0, record);
    add_char(letter, 1'b1, record);
    arrow_count++;
  endfunction

  function automatic void decode_scan_byte(input logic [7:0] b, input bit record);
    logic [6:0] key;
    logic [7:0] code;
    logic [7:0] ch;
    key = b[6:0];
    code = (key < KEY_COUNT) ? PLAIN_KEYS[key] : 8'h00;
    ch = (shift_on && key < KEY_COUNT) ? SHIFTED_KEYS[key] : code;
    if (b[7]) begin
      if (code == scst_pkg::K_SHIFT) shift_on = 1'b0;
      else if (code == scst_pkg::K_CTRL) ctrl_on = 1'b0;
      else if (code == scst_pkg::K_ALT) alt_on = 1'b0;
    end else if (code == scst_pkg::K_SHIFT) begin
      shift_on = 1'b1;
    end else if (code == scst_pkg::K_CTRL) begin
      ctrl_on = 1'b1;
    end else if (code == scst_pkg::K_ALT) begin
      alt_on = 1'b1;
    end else if (code == scst_pkg::K_BACKSPACE) begin
      add_char(scst_pkg::CH_BS, 1'b0, record);
      add_char(scst_pkg::CH_SPACE, 1'b0, record);
      add_char(scst_pkg::CH_BS, 1'b1, record);
    end else if (code == scst_pkg::K_ENTER) begin
      add_char(scst_pkg::CH_LF, 1'b1, record);
    end else if (prior_byte != scst_pkg::PREFIX_E0) begin
      if (ctrl_on && code == scst_pkg::KEY_C) begin
        for (int k = 0; k < 7; k++) add_char(CLEAR_SEQ[k], k == 6, record);
        clear_count++;
      end else if (ch != 8'h00) begin
        add_char(ch, 1'b1, record);
      end
    end else begin
      case (b)
        scst_pkg::SC_UP:    add_arrow(scst_pkg::CH_A, record);
        scst_pkg::SC_LEFT:  add_arrow(scst_pkg::CH_D, record);
        scst_pkg::SC_RIGHT: add_arrow(scst_pkg::CH_C, record);
        scst_pkg::SC_DOWN:  add_arrow(scst_pkg::CH_B, record);
        default: ;
      endcase
    end
    prior_byte = b;
  endfunction

  task automatic send_scan(input logic [7:0] b, input bit typed, input bit has_char,
                           input logic [7:0] ch);
    if (burst_left == 0) begin
      in_push <= 1'b0;
      in_scan_byte <= 8'($urandom);
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    in_push <= 1'b1;
    in_scan_byte <= b;
    @(posedge clk);
    while (in_full) @(posedge clk);
    decode_scan_byte(b, !typed);
    if (typed && has_char) pending_chars.push_back(term_char_t'{ch, 1'b1});
    if (!no_gaps) burst_left--;
    sent_count++;
  endtask

  initial begin
    int unsigned cyc;
    cyc = 0;
    forever begin
      @(posedge clk);
      if (hold_outputs) begin
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_outputs = 1'b0;
      end else begin
        cyc++;
        case ((cyc / 40) % 4)
          0: out_pop <= 1'b1;
          1: out_pop <= 1'($urandom_range(0, 1));
          2: out_pop <= (cyc % 7) != 0;
          default: out_pop <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_chars
    term_char_t want;
    if (rst_n && out_pop && !out_empty) begin
      char_count++;
      if (pending_chars.size() == 0) begin
        $error("Unexpected character: char_code %h, last_char %b", out_char_code,
               out_last_char);
        fail_count++;
      end else begin
        want = pending_chars.pop_front();
        if (out_char_code !== want.code) begin
          $error("char_code: expected %h, actual %h", want.code, out_char_code);
          fail_count++;
        end
        if (out_last_char !== want.last) begin
          $error("last_char: expected %b, actual %b", want.last, out_last_char);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int unsigned i;
    int unsigned r;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (key_script[n]) begin
      send_scan(key_script[n].scan, key_script[n].typed, key_script[n].has_char,
                key_script[n].ch);
    end

    in_push <= 1'b0;
    do @(posedge clk); while (pending_chars.size() != 0);

    // Stall the output for a long stretch while letter keys keep arriving.
    hold_outputs = 1'b1;
    no_gaps = 1'b1;
    repeat (24) send_scan(8'($urandom_range(16, 25)), 1'b0, 1'b0, 8'h00);
    no_gaps = 1'b0;

    i = 0;
    while (i < RANDOM_KEYS) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        send_scan(8'($urandom_range(0, KEY_COUNT - 1)), 1'b0, 1'b0, 8'h00);
        i++;
      end else if (r < 60) begin
        send_scan(MOD_KEYS[$urandom_range(0, 3)] | ($urandom_range(0, 1) ? RELEASE_BIT : 8'h00),
                  1'b0, 1'b0, 8'h00);
        i++;
      end else if (r < 75) begin
        send_scan(scst_pkg::PREFIX_E0, 1'b0, 1'b0, 8'h00);
        if ($urandom_range(0, 3) == 0) send_scan(8'($urandom), 1'b0, 1'b0, 8'h00);
        else send_scan(ARROW_KEYS[$urandom_range(0, 3)], 1'b0, 1'b0, 8'h00);
        i += 2;
      end else if (r < 85) begin
        send_scan(RELEASE_BIT | 8'($urandom_range(0, 127)), 1'b0, 1'b0, 8'h00);
        i++;
      end else if (r < 90) begin
        send_scan(SC_CTRL, 1'b0, 1'b0, 8'h00);
        send_scan(SC_KEY_C, 1'b0, 1'b0, 8'h00);
        send_scan(SC_CTRL | RELEASE_BIT, 1'b0, 1'b0, 8'h00);
        i += 3;
      end else begin
        send_scan(8'($urandom), 1'b0, 1'b0, 8'h00);
        i++;
      end
    end

    in_push <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d scan bytes and checked %0d characters, with %0d clear-screen and",
             sent_count, char_count, clear_count);
    $display("%0d cursor sequences, under a long output stall, a drain pause and random gaps.",
             arrow_count);
    if (fail_count == 0 && pending_chars.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/scst_pkg.sv
hdl/scst_front.sv
hdl/scst_cmd_fifo.sv
hdl/scst_back.sv
hdl/scan_set1_to_terminal_chars.sv
bench/testbench.sv
